>>> rtl/core/tile_grid_loader_autotiler_macros.svh
// Assertion helpers for the tile grid loader checker.
// Both expect signals named clk and rst_n in the scope where they are used.
`ifndef TILE_GRID_LOADER_AUTOTILER_MACROS_SVH
`define TILE_GRID_LOADER_AUTOTILER_MACROS_SVH

// Same-cycle implication.
`define TGLA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tgla assertion failed");

// Next-cycle implication.
`define TGLA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tgla assertion failed");

`endif

>>> rtl/core/tgla_pkg.sv
`default_nettype none

package tgla_pkg;

    // Request codes
    localparam logic [2:0] REQ_CHAR  = 3'd0;
    localparam logic [2:0] REQ_END   = 3'd1;
    localparam logic [2:0] REQ_QUERY = 3'd2;
    localparam logic [2:0] REQ_READ  = 3'd3;
    localparam logic [2:0] REQ_WRITE = 3'd4;

    // Cell kinds
    localparam logic [2:0] KIND_EMPTY = 3'd0;
    localparam logic [2:0] KIND_PATH  = 3'd1;
    localparam logic [2:0] KIND_SPAWN = 3'd2;
    localparam logic [2:0] KIND_GOAL  = 3'd3;
    localparam logic [2:0] KIND_TOWER = 3'd4;

    // Level text bytes
    localparam logic [7:0] SYM_EMPTY = 8'h2E;
    localparam logic [7:0] SYM_PATH  = 8'h23;
    localparam logic [7:0] SYM_SPAWN = 8'h53;
    localparam logic [7:0] SYM_GOAL  = 8'h47;
    localparam logic [7:0] SYM_TOWER = 8'h54;
    localparam logic [7:0] SYM_CR    = 8'h0D;
    localparam logic [7:0] SYM_LF    = 8'h0A;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 1'b1;
    localparam logic [6:0] CFG_DIM_RESET = 7'd64;

    // Tile picked for a cell with no path-like neighbor
    localparam logic [2:0] SHEET_ISO_COL = 3'd4;
    localparam logic [2:0] SHEET_ISO_ROW = 3'd2;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] symbol;
        logic [5:0] x_coord;
        logic [5:0] y_coord;
        logic [2:0] tile_value;
    } req_t;

    typedef struct packed {
        logic       status;
        logic [2:0] tile_out;
        logic [3:0] neighbor_mask;
        logic [2:0] sheet_col;
        logic [2:0] sheet_row;
        logic [5:0] spawn_col;
        logic [5:0] spawn_row;
        logic       spawn_seen;
        logic [5:0] goal_col;
        logic [5:0] goal_row;
        logic       goal_seen;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_QN,
        ST_QS,
        ST_QE,
        ST_QW,
        ST_FIN
    } state_t;

    typedef enum logic [2:0] {
        AS_CENTER,
        AS_NORTH,
        AS_SOUTH,
        AS_EAST,
        AS_WEST
    } addr_sel_t;

    typedef enum logic [2:0] {
        CAP_NONE,
        CAP_CENTER,
        CAP_NORTH,
        CAP_SOUTH,
        CAP_EAST
    } cap_sel_t;

    typedef struct packed {
        logic      latch;
        logic      exec;
        logic      rd_en;
        addr_sel_t rd_sel;
        cap_sel_t  cap;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        logic is_query;
        logic is_read;
    } stat_t;

    typedef struct packed {
        logic [2:0] col;
        logic [2:0] row;
    } sheet_t;

    function automatic logic pathlike(input logic [2:0] kind);
        return (kind == KIND_PATH) || (kind == KIND_SPAWN) || (kind == KIND_GOAL);
    endfunction

    // Tileset position for a N/S/E/W neighbor mask
    function automatic sheet_t sheet_lookup(input logic [3:0] mask);
        sheet_t s;
        case (mask)
            4'd1:    s = '{col: 3'd3, row: 3'd4};
            4'd2:    s = '{col: 3'd2, row: 3'd4};
            4'd3:    s = '{col: 3'd0, row: 3'd0};
            4'd4:    s = '{col: 3'd0, row: 3'd4};
            4'd5:    s = '{col: 3'd5, row: 3'd0};
            4'd6:    s = '{col: 3'd2, row: 3'd0};
            4'd8:    s = '{col: 3'd1, row: 3'd4};
            4'd9:    s = '{col: 3'd4, row: 3'd0};
            4'd10:   s = '{col: 3'd3, row: 3'd0};
            4'd12:   s = '{col: 3'd1, row: 3'd0};
            default: s = '{col: SHEET_ISO_COL, row: SHEET_ISO_ROW};
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/tgla_req_if.sv
`default_nettype none

interface tgla_req_if import tgla_pkg::*;;
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tgla_rsp_if.sv
`default_nettype none

interface tgla_rsp_if import tgla_pkg::*;;
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tgla_ctrl.sv
`default_nettype none

module tgla_ctrl
    import tgla_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_ready,
    output logic  rsp_valid,
    input  logic  rsp_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || rsp_ready;

    // Sequence one item: execute, walk neighbors for a query, then hand off
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC: state_next = stat.is_query ? ST_QN : ST_FIN;
            ST_QN:   state_next = ST_QS;
            ST_QS:   state_next = ST_QE;
            ST_QE:   state_next = ST_QW;
            ST_QW:   state_next = ST_FIN;
            ST_FIN:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Drive datapath commands per state
    always_comb
    begin
        cmd = '{latch: 1'b0, exec: 1'b0, rd_en: 1'b0, rd_sel: AS_CENTER,
                cap: CAP_NONE, out_load: 1'b0};
        req_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.latch = req_valid;
            end
            ST_EXEC:
            begin
                cmd.exec  = 1'b1;
                cmd.rd_en = stat.is_query || stat.is_read;
            end
            ST_QN:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = AS_NORTH;
                cmd.cap    = CAP_CENTER;
            end
            ST_QS:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = AS_SOUTH;
                cmd.cap    = CAP_NORTH;
            end
            ST_QE:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = AS_EAST;
                cmd.cap    = CAP_SOUTH;
            end
            ST_QW:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = AS_WEST;
                cmd.cap    = CAP_EAST;
            end
            ST_FIN:  cmd.out_load = slot_free;
            default: req_ready = 1'b0;
        endcase
    end

    // Hold the result valid until taken
    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign rsp_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/tgla_dpath.sv
`default_nettype none

module tgla_dpath
    import tgla_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  req_t                 req_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [6:0]           cfg_wdata,
    input  cmd_t                 cmd,
    output stat_t                stat,
    output rsp_t                 rsp_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Latched item and configuration
    req_t       in_reg;
    logic [6:0] width_reg;
    logic [6:0] height_reg;

    // Load and map state
    logic       map_valid_reg,   map_valid_next;
    logic       load_active_reg, load_active_next;
    logic       load_failed_reg, load_failed_next;
    logic [6:0] row_count_reg,   row_count_next;
    logic [6:0] col_count_reg,   col_count_next;
    logic [5:0] spawn_col_reg,   spawn_col_next;
    logic [5:0] spawn_row_reg,   spawn_row_next;
    logic       spawn_flag_reg,  spawn_flag_next;
    logic [5:0] goal_col_reg,    goal_col_next;
    logic [5:0] goal_row_reg,    goal_row_next;
    logic       goal_flag_reg,   goal_flag_next;
    logic       status_pend_reg, status_pend_next;

    // Cell memory port
    logic [2:0]    cell_mem [DEPTH];
    logic [2:0]    rdata_reg;
    logic          mem_we;
    logic [2:0]    mem_wdata;
    logic [AW-1:0] mem_addr;
    logic [31:0]   addr_full;
    logic [6:0]    row_sel;
    logic [6:0]    col_sel;

    // Query captures
    logic [2:0] tile_cap_reg;
    logic       cap_n_reg;
    logic       cap_s_reg;
    logic       cap_e_reg;

    logic       geom_ok;
    logic       in_map;
    logic       start_load;
    logic       lf_eff;
    logic [6:0] eff_row;
    logic [6:0] eff_col;
    logic       sym_ok;
    logic [2:0] sym_kind;
    logic       do_fail;
    logic       end_ok;
    logic       gn, gs, ge, gw;
    logic       is_query;
    logic       is_read;
    logic [3:0] mask;
    sheet_t     sheet;
    rsp_t       out_reg;
    rsp_t       out_next;

    assign is_query = (in_reg.req_type == REQ_QUERY);
    assign is_read  = (in_reg.req_type == REQ_READ);
    assign stat     = '{is_query: is_query, is_read: is_read};

    assign geom_ok = (width_reg != 7'd0) && (32'(width_reg) <= 32'(MAX_WIDTH)) &&
                     (height_reg != 7'd0) && (32'(height_reg) <= 32'(MAX_HEIGHT));
    assign in_map  = map_valid_reg && geom_ok &&
                     ({1'b0, in_reg.x_coord} < width_reg) &&
                     ({1'b0, in_reg.y_coord} < height_reg);

    // Neighbor guards at the map edge
    assign gn = (in_reg.y_coord != 6'd0);
    assign gs = (({1'b0, in_reg.y_coord} + 7'd1) < height_reg);
    assign ge = (({1'b0, in_reg.x_coord} + 7'd1) < width_reg);
    assign gw = (in_reg.x_coord != 6'd0);

    // Counters as seen by a byte that may open a new load
    assign start_load = !load_active_reg;
    assign lf_eff     = start_load ? 1'b0 : load_failed_reg;
    assign eff_row    = start_load ? 7'd0 : row_count_reg;
    assign eff_col    = start_load ? 7'd0 : col_count_reg;

    assign end_ok = geom_ok &&
        ((eff_row == height_reg && eff_col == 7'd0) ||
         (({1'b0, eff_row} + 8'd1) == {1'b0, height_reg} && eff_col == width_reg));

    // Decode a level byte
    always_comb
    begin
        sym_ok   = 1'b1;
        sym_kind = KIND_EMPTY;
        case (in_reg.symbol)
            SYM_EMPTY: sym_kind = KIND_EMPTY;
            SYM_PATH:  sym_kind = KIND_PATH;
            SYM_SPAWN: sym_kind = KIND_SPAWN;
            SYM_GOAL:  sym_kind = KIND_GOAL;
            SYM_TOWER: sym_kind = KIND_TOWER;
            default:   sym_ok   = 1'b0;
        endcase
    end

    // Select the cell address
    always_comb
    begin
        row_sel = {1'b0, in_reg.y_coord};
        col_sel = {1'b0, in_reg.x_coord};
        case (cmd.rd_sel)
            AS_CENTER: ;
            AS_NORTH:  row_sel = {1'b0, in_reg.y_coord} - 7'd1;
            AS_SOUTH:  row_sel = {1'b0, in_reg.y_coord} + 7'd1;
            AS_EAST:   col_sel = {1'b0, in_reg.x_coord} + 7'd1;
            AS_WEST:   col_sel = {1'b0, in_reg.x_coord} - 7'd1;
            default:   ;
        endcase
        if (cmd.exec && in_reg.req_type == REQ_CHAR)
        begin
            row_sel = eff_row;
            col_sel = eff_col;
        end
    end

    assign addr_full = 32'(row_sel) * 32'(MAX_WIDTH) + 32'(col_sel);
    assign mem_addr  = addr_full[AW-1:0];

    // Execute one item against the load state
    always_comb
    begin
        map_valid_next   = map_valid_reg;
        load_active_next = load_active_reg;
        load_failed_next = load_failed_reg;
        row_count_next   = row_count_reg;
        col_count_next   = col_count_reg;
        spawn_col_next   = spawn_col_reg;
        spawn_row_next   = spawn_row_reg;
        spawn_flag_next  = spawn_flag_reg;
        goal_col_next    = goal_col_reg;
        goal_row_next    = goal_row_reg;
        goal_flag_next   = goal_flag_reg;
        status_pend_next = status_pend_reg;
        mem_we           = 1'b0;
        mem_wdata        = sym_kind;
        do_fail          = 1'b0;

        if (cmd.exec)
        begin
            // Open a load on its first byte or end mark
            if ((in_reg.req_type == REQ_CHAR || in_reg.req_type == REQ_END) && start_load)
            begin
                load_active_next = 1'b1;
                load_failed_next = 1'b0;
                map_valid_next   = 1'b0;
                row_count_next   = 7'd0;
                col_count_next   = 7'd0;
                spawn_flag_next  = 1'b0;
                goal_flag_next   = 1'b0;
                spawn_col_next   = 6'd0;
                spawn_row_next   = 6'd0;
                goal_col_next    = 6'd0;
                goal_row_next    = 6'd0;
            end

            case (in_reg.req_type)
                REQ_CHAR:
                begin
                    if (lf_eff || in_reg.symbol == SYM_CR)
                        do_fail = 1'b0;
                    else if (!geom_ok)
                        do_fail = 1'b1;
                    else if (in_reg.symbol == SYM_LF)
                    begin
                        if (eff_col != width_reg)
                            do_fail = 1'b1;
                        else
                        begin
                            row_count_next = eff_row + 7'd1;
                            col_count_next = 7'd0;
                        end
                    end
                    else if (eff_row >= height_reg || eff_col >= width_reg || !sym_ok)
                        do_fail = 1'b1;
                    else
                    begin
                        mem_we         = 1'b1;
                        col_count_next = eff_col + 7'd1;
                        if (sym_kind == KIND_SPAWN)
                        begin
                            spawn_flag_next = 1'b1;
                            spawn_col_next  = eff_col[5:0];
                            spawn_row_next  = eff_row[5:0];
                        end
                        if (sym_kind == KIND_GOAL)
                        begin
                            goal_flag_next = 1'b1;
                            goal_col_next  = eff_col[5:0];
                            goal_row_next  = eff_row[5:0];
                        end
                    end
                end
                REQ_END:
                begin
                    if (!lf_eff)
                    begin
                        if (end_ok)
                            map_valid_next = 1'b1;
                        else
                            do_fail = 1'b1;
                    end
                end
                REQ_QUERY: status_pend_next = 1'b0;
                REQ_READ:  status_pend_next = 1'b0;
                REQ_WRITE:
                begin
                    mem_wdata = in_reg.tile_value;
                    if (in_map && in_reg.tile_value <= KIND_TOWER)
                    begin
                        mem_we           = 1'b1;
                        status_pend_next = 1'b0;
                    end
                    else
                        status_pend_next = 1'b1;
                end
                default: status_pend_next = 1'b1;
            endcase

            // Drop the map and marks on a failed load
            if (do_fail)
            begin
                load_failed_next = 1'b1;
                map_valid_next   = 1'b0;
                spawn_flag_next  = 1'b0;
                goal_flag_next   = 1'b0;
                spawn_col_next   = 6'd0;
                spawn_row_next   = 6'd0;
                goal_col_next    = 6'd0;
                goal_row_next    = 6'd0;
            end

            if (in_reg.req_type == REQ_CHAR)
                status_pend_next = load_failed_next;

            // Close the load after reporting its outcome
            if (in_reg.req_type == REQ_END)
            begin
                status_pend_next = load_failed_next;
                load_active_next = 1'b0;
                load_failed_next = 1'b0;
                row_count_next   = 7'd0;
                col_count_next   = 7'd0;
            end
        end
    end

    // Single-port cell memory with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            cell_mem[mem_addr] <= mem_wdata;
        else if (cmd.rd_en)
            rdata_reg <= cell_mem[mem_addr];
    end

    // Capture the item and the query reads
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
            in_reg <= req_data;
        case (cmd.cap)
            CAP_CENTER: tile_cap_reg <= rdata_reg;
            CAP_NORTH:  cap_n_reg    <= pathlike(rdata_reg);
            CAP_SOUTH:  cap_s_reg    <= pathlike(rdata_reg);
            CAP_EAST:   cap_e_reg    <= pathlike(rdata_reg);
            default:    ;
        endcase
        if (cmd.out_load)
            out_reg <= out_next;
    end

    // Build the result item
    always_comb
    begin
        mask = 4'd0;
        if (is_query && in_map)
            mask = {gw && pathlike(rdata_reg), ge && cap_e_reg, gs && cap_s_reg, gn && cap_n_reg};
        sheet = sheet_lookup(mask);

        out_next               = '0;
        out_next.status        = status_pend_reg;
        out_next.neighbor_mask = mask;
        if (is_query)
        begin
            out_next.sheet_col = sheet.col;
            out_next.sheet_row = sheet.row;
            out_next.tile_out  = in_map ? tile_cap_reg : KIND_EMPTY;
        end
        else if (is_read)
            out_next.tile_out  = in_map ? rdata_reg : KIND_EMPTY;
        out_next.spawn_col     = spawn_col_reg;
        out_next.spawn_row     = spawn_row_reg;
        out_next.spawn_seen    = spawn_flag_reg;
        out_next.goal_col      = goal_col_reg;
        out_next.goal_row      = goal_row_reg;
        out_next.goal_seen     = goal_flag_reg;
    end

    assign rsp_data = out_reg;

    // Configuration and load state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg       <= CFG_DIM_RESET;
            height_reg      <= CFG_DIM_RESET;
            map_valid_reg   <= 1'b0;
            load_active_reg <= 1'b0;
            load_failed_reg <= 1'b0;
            row_count_reg   <= 7'd0;
            col_count_reg   <= 7'd0;
            spawn_col_reg   <= 6'd0;
            spawn_row_reg   <= 6'd0;
            spawn_flag_reg  <= 1'b0;
            goal_col_reg    <= 6'd0;
            goal_row_reg    <= 6'd0;
            goal_flag_reg   <= 1'b0;
            status_pend_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MAP_WIDTH:  width_reg  <= cfg_wdata;
                    CFG_MAP_HEIGHT: height_reg <= cfg_wdata;
                    default:        ;
                endcase
            end
            map_valid_reg   <= map_valid_next;
            load_active_reg <= load_active_next;
            load_failed_reg <= load_failed_next;
            row_count_reg   <= row_count_next;
            col_count_reg   <= col_count_next;
            spawn_col_reg   <= spawn_col_next;
            spawn_row_reg   <= spawn_row_next;
            spawn_flag_reg  <= spawn_flag_next;
            goal_col_reg    <= goal_col_next;
            goal_row_reg    <= goal_row_next;
            goal_flag_reg   <= goal_flag_next;
            status_pend_reg <= status_pend_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/tile_grid_loader_autotiler.sv
// Each item runs through the EXEC and FIN states, an autotile query also through QN, QS,
// QE and QW; no new item is accepted until the last has left FIN. The query walks the
// center and four neighbor cells through the single-port cell memory, one read per cycle.
// The output register holds a result while the next item is taken in.
// Reset: controller, load state, spawn/goal marks clear; width and height return to 64.
// The cell memory is not cleared; no clearing pass runs after reset.
`default_nettype none

module tile_grid_loader_autotiler
    import tgla_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    tgla_req_if.sink             req,
    tgla_rsp_if.source           rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [6:0]           cfg_wdata
);

    cmd_t  cmd;
    stat_t stat;

    tgla_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tgla_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req.data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_data  (rsp.data)
    );

endmodule

`default_nettype wire

>>> rtl/core/tgla_checker.sv
`default_nettype none
`include "tile_grid_loader_autotiler_macros.svh"

module tgla_checker
    import tgla_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp_data
);

    // A pending result stays offered until taken
    `TGLA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

    // One item in work at a time: no accept right after an accept
    `TGLA_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)

    // An empty mask picks the isolated tile, or no tile for a non-query item
    `TGLA_ASSERT_NOW(a_mask_sheet, rsp_valid && rsp_data.neighbor_mask == 4'd0, (rsp_data.sheet_col == SHEET_ISO_COL && rsp_data.sheet_row == SHEET_ISO_ROW) || (rsp_data.sheet_col == 3'd0 && rsp_data.sheet_row == 3'd0))

    // A spawn mark without a spawn symbol seen reads as zero
    `TGLA_ASSERT_NOW(a_spawn_clear, rsp_valid && !rsp_data.spawn_seen, rsp_data.spawn_col == 6'd0 && rsp_data.spawn_row == 6'd0)

endmodule

bind tile_grid_loader_autotiler tgla_checker u_tgla_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

`default_nettype wire
